>>> src/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Types, widths and helpers shared by the ray / triangle intersection pipe.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int CW  = 32;   // coordinate width, Q16.16
	localparam int EW  = 33;   // edge / origin offset width
	localparam int MW  = 66;   // cross product term width
	localparam int PW  = 67;   // cross product width
	localparam int LW  = 34;   // low split of a cross product component
	localparam int DW  = 100;  // dot product width, Q52.48
	localparam int UW  = 99;   // magnitude bits of a positive dot product
	localparam int QW  = 31;   // distance width
	localparam int RW  = 130;  // divider remainder width
	localparam int IW  = 3;    // config index width
	localparam int NDOT = 4;
	localparam int NTERM = 12;

	localparam logic [QW-1:0] DIST_MAX = {QW{1'b1}};

	typedef enum logic [IW-1:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_ORIGIN_Z    = 3'd2,
		REG_DIRECTION_X = 3'd3,
		REG_DIRECTION_Y = 3'd4,
		REG_DIRECTION_Z = 3'd5
	} rti_reg_e;

	typedef struct packed {
		logic signed [CW-1:0] vertex_a_x;
		logic signed [CW-1:0] vertex_a_y;
		logic signed [CW-1:0] vertex_a_z;
		logic signed [CW-1:0] vertex_b_x;
		logic signed [CW-1:0] vertex_b_y;
		logic signed [CW-1:0] vertex_b_z;
		logic signed [CW-1:0] vertex_c_x;
		logic signed [CW-1:0] vertex_c_y;
		logic signed [CW-1:0] vertex_c_z;
	} rti_in_t;

	typedef struct packed {
		logic          hit;
		logic [QW-1:0] distance;
	} rti_out_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} rti_v32_t;

	typedef struct packed {
		logic signed [EW-1:0] x;
		logic signed [EW-1:0] y;
		logic signed [EW-1:0] z;
	} rti_v33_t;

	typedef struct packed {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic signed [PW-1:0] z;
	} rti_v67_t;

	// front end to dot stage
	typedef struct packed {
		rti_v33_t e1;
		rti_v33_t e2;
		rti_v33_t s;
		rti_v33_t d;
		rti_v67_t p;
		rti_v67_t q;
	} rti_geo_t;

	// dot stage to divider
	typedef struct packed {
		logic          miss;
		logic          sat;
		logic [UW-1:0] num;
		logic [UW-1:0] den;
	} rti_div_t;

	function automatic logic signed [EW-1:0] sx33(input logic signed [CW-1:0] a);
		return {a[CW-1], a};
	endfunction

	function automatic logic signed [PW-1:0] sx67(input logic signed [MW-1:0] a);
		return {a[MW-1], a};
	endfunction

endpackage

>>> src/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front
// Edge vectors, origin offset and the two cross products (three stages).
// ----------------------------------------------------------------------------
module rti_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  rti_pkg::rti_in_t vtx,
	input  rti_pkg::rti_v32_t origin,
	input  rti_pkg::rti_v32_t dir,
	output logic             out_valid,
	output rti_pkg::rti_geo_t geo
);
	import rti_pkg::*;

	logic     v_s1, v_s2, v_s3;
	rti_v33_t e1_s1, e2_s1, s_s1, d_s1;
	rti_v33_t e1_s2, e2_s2, s_s2, d_s2;
	logic signed [MW-1:0] prod_s2 [NTERM];
	rti_geo_t geo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// S1: differences
	always_ff @(posedge clk) begin
		e1_s1.x <= sx33(vtx.vertex_b_x) - sx33(vtx.vertex_a_x);
		e1_s1.y <= sx33(vtx.vertex_b_y) - sx33(vtx.vertex_a_y);
		e1_s1.z <= sx33(vtx.vertex_b_z) - sx33(vtx.vertex_a_z);
		e2_s1.x <= sx33(vtx.vertex_c_x) - sx33(vtx.vertex_a_x);
		e2_s1.y <= sx33(vtx.vertex_c_y) - sx33(vtx.vertex_a_y);
		e2_s1.z <= sx33(vtx.vertex_c_z) - sx33(vtx.vertex_a_z);
		s_s1.x  <= sx33(origin.x) - sx33(vtx.vertex_a_x);
		s_s1.y  <= sx33(origin.y) - sx33(vtx.vertex_a_y);
		s_s1.z  <= sx33(origin.z) - sx33(vtx.vertex_a_z);
		d_s1.x  <= sx33(dir.x);
		d_s1.y  <= sx33(dir.y);
		d_s1.z  <= sx33(dir.z);
	end

	// S2: the twelve cross product terms, p = d x e2, q = s x e1
	always_ff @(posedge clk) begin
		prod_s2[0]  <= d_s1.y * e2_s1.z;
		prod_s2[1]  <= d_s1.z * e2_s1.y;
		prod_s2[2]  <= d_s1.z * e2_s1.x;
		prod_s2[3]  <= d_s1.x * e2_s1.z;
		prod_s2[4]  <= d_s1.x * e2_s1.y;
		prod_s2[5]  <= d_s1.y * e2_s1.x;
		prod_s2[6]  <= s_s1.y * e1_s1.z;
		prod_s2[7]  <= s_s1.z * e1_s1.y;
		prod_s2[8]  <= s_s1.z * e1_s1.x;
		prod_s2[9]  <= s_s1.x * e1_s1.z;
		prod_s2[10] <= s_s1.x * e1_s1.y;
		prod_s2[11] <= s_s1.y * e1_s1.x;
		e1_s2 <= e1_s1;
		e2_s2 <= e2_s1;
		s_s2  <= s_s1;
		d_s2  <= d_s1;
	end

	// S3: cross product components
	always_ff @(posedge clk) begin
		geo_s3.p.x <= sx67(prod_s2[0])  - sx67(prod_s2[1]);
		geo_s3.p.y <= sx67(prod_s2[2])  - sx67(prod_s2[3]);
		geo_s3.p.z <= sx67(prod_s2[4])  - sx67(prod_s2[5]);
		geo_s3.q.x <= sx67(prod_s2[6])  - sx67(prod_s2[7]);
		geo_s3.q.y <= sx67(prod_s2[8])  - sx67(prod_s2[9]);
		geo_s3.q.z <= sx67(prod_s2[10]) - sx67(prod_s2[11]);
		geo_s3.e1  <= e1_s2;
		geo_s3.e2  <= e2_s2;
		geo_s3.s   <= s_s2;
		geo_s3.d   <= d_s2;
	end

	assign out_valid = v_s3;
	assign geo       = geo_s3;

endmodule

>>> src/rti_dot.sv
// ----------------------------------------------------------------------------
// rti_dot
// det, u, v and n as 33x67 products split at bit 34, then the hit / bound decisions.
// ----------------------------------------------------------------------------
module rti_dot (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rti_pkg::rti_geo_t geo,
	output logic              out_valid,
	output rti_pkg::rti_div_t dv
);
	import rti_pkg::*;

	localparam logic signed [DW-1:0] DET_MIN = {{(DW-33){1'b0}}, 1'b1, 32'b0};

	logic v_s4, v_s5, v_s6, v_s7;
	logic signed [EW-1:0] mul_a [NTERM];
	logic signed [PW-1:0] mul_b [NTERM];
	logic signed [MW-1:0]   hi_s4 [NTERM];
	logic signed [MW+1:0]   lo_s4 [NTERM];
	logic signed [DW-1:0]   term_s5 [NTERM];
	logic signed [DW-1:0]   dot_s6 [NDOT];
	logic signed [DW:0]     uv_sum;
	rti_div_t dv_s7;

	// operand routing: det = e1.p, u = s.p, v = d.q, n = e2.q
	always_comb begin
		mul_a[0]  = geo.e1.x; mul_b[0]  = geo.p.x;
		mul_a[1]  = geo.e1.y; mul_b[1]  = geo.p.y;
		mul_a[2]  = geo.e1.z; mul_b[2]  = geo.p.z;
		mul_a[3]  = geo.s.x;  mul_b[3]  = geo.p.x;
		mul_a[4]  = geo.s.y;  mul_b[4]  = geo.p.y;
		mul_a[5]  = geo.s.z;  mul_b[5]  = geo.p.z;
		mul_a[6]  = geo.d.x;  mul_b[6]  = geo.q.x;
		mul_a[7]  = geo.d.y;  mul_b[7]  = geo.q.y;
		mul_a[8]  = geo.d.z;  mul_b[8]  = geo.q.z;
		mul_a[9]  = geo.e2.x; mul_b[9]  = geo.q.x;
		mul_a[10] = geo.e2.y; mul_b[10] = geo.q.y;
		mul_a[11] = geo.e2.z; mul_b[11] = geo.q.z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// S4: high part signed, low part unsigned
	always_ff @(posedge clk) begin
		for (int i = 0; i < NTERM; i++) begin
			hi_s4[i] <= mul_a[i] * $signed(mul_b[i][PW-1:LW]);
			lo_s4[i] <= mul_a[i] * $signed({1'b0, mul_b[i][LW-1:0]});
		end
	end

	// S5: recombine each term
	always_ff @(posedge clk) begin
		for (int i = 0; i < NTERM; i++) begin
			term_s5[i] <= $signed({hi_s4[i], {LW{1'b0}}})
				+ $signed({{(DW-MW-2){lo_s4[i][MW+1]}}, lo_s4[i]});
		end
	end

	// S6: three-term sums
	always_ff @(posedge clk) begin
		for (int k = 0; k < NDOT; k++) begin
			dot_s6[k] <= term_s5[3*k] + term_s5[3*k+1] + term_s5[3*k+2];
		end
	end

	assign uv_sum = {dot_s6[1][DW-1], dot_s6[1]} + {dot_s6[2][DW-1], dot_s6[2]};

	// S7: decisions; det = dot 0, u = dot 1, v = dot 2, n = dot 3
	always_ff @(posedge clk) begin
		dv_s7.miss <= (dot_s6[0] < DET_MIN)
			|| dot_s6[1][DW-1] || (dot_s6[1] > dot_s6[0])
			|| dot_s6[2][DW-1] || (uv_sum > $signed({dot_s6[0][DW-1], dot_s6[0]}))
			|| dot_s6[3][DW-1] || (dot_s6[3] == '0);
		dv_s7.sat  <= {15'b0, dot_s6[3][UW-1:0]} >= {dot_s6[0][UW-1:0], 15'b0};
		dv_s7.num  <= dot_s6[3][UW-1:0];
		dv_s7.den  <= dot_s6[0][UW-1:0];
	end

	assign out_valid = v_s7;
	assign dv        = dv_s7;

endmodule

>>> src/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Restoring divider, one quotient bit per stage: t = floor(n * 2^16 / det).
// ----------------------------------------------------------------------------
module rti_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rti_pkg::rti_div_t dv,
	output logic              out_valid,
	output rti_pkg::rti_out_t res
);
	import rti_pkg::*;

	logic          vld_s  [QW];
	logic          miss_s [QW];
	logic          sat_s  [QW];
	logic [RW-1:0] rem_s  [QW];
	logic [UW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW];

	logic          vld_in  [QW];
	logic          miss_in [QW];
	logic          sat_in  [QW];
	logic [RW-1:0] rem_in  [QW];
	logic [UW-1:0] den_in  [QW];
	logic [QW-1:0] quo_in  [QW];

	logic          miss_last;
	logic          sat_last;
	logic [QW-1:0] quo_last;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int J = QW - 1 - k;
		logic [RW-1:0] dsh;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_in[k]  = in_valid;
			assign miss_in[k] = dv.miss;
			assign sat_in[k]  = dv.sat;
			assign rem_in[k]  = {{(RW-UW-16){1'b0}}, dv.num, 16'b0};
			assign den_in[k]  = dv.den;
			assign quo_in[k]  = '0;
		end else begin : g_next
			assign vld_in[k]  = vld_s[k-1];
			assign miss_in[k] = miss_s[k-1];
			assign sat_in[k]  = sat_s[k-1];
			assign rem_in[k]  = rem_s[k-1];
			assign den_in[k]  = den_s[k-1];
			assign quo_in[k]  = quo_s[k-1];
		end

		assign dsh = {{(RW-UW){1'b0}}, den_in[k]} << J;
		assign ge  = rem_in[k] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in[k];
			end
		end

		always_ff @(posedge clk) begin
			miss_s[k] <= miss_in[k];
			sat_s[k]  <= sat_in[k];
			den_s[k]  <= den_in[k];
			rem_s[k]  <= ge ? rem_in[k] - dsh : rem_in[k];
			quo_s[k]  <= quo_in[k] | (QW'(ge) << J);
		end
	end

	assign miss_last = miss_s[QW-1];
	assign sat_last  = sat_s[QW-1];
	assign quo_last  = quo_s[QW-1];

	assign out_valid = vld_s[QW-1];

	always_comb begin
		if (miss_last) begin
			res.hit      = 1'b0;
			res.distance = '0;
		end else if (sat_last) begin
			res.hit      = 1'b1;
			res.distance = DIST_MAX;
		end else begin
			res.hit      = quo_last != '0;
			res.distance = quo_last;
		end
	end

endmodule

>>> src/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Back-face culled ray / triangle test in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Ray origin and direction are loaded over the config channel (cfg_valid,
//   cfg_ready, cfg_index, cfg_data); index 0..2 origin x/y/z, 3..5 direction
//   x/y/z, other indexes ignored. cfg_ready is always high. Load them only
//   while no triangle is in flight.
//   A triangle beat is taken at each rising edge with start high and busy
//   low. busy is always low: the pipe takes one triangle every cycle.
//   Each triangle yields one result beat: done is high for one cycle with
//   result valid; that beat is taken at the edge ending that cycle. The
//   result beat passes through 3 stages of edge / cross product math, 4
//   stages of split dot products and bound checks, 31 divider stages (one
//   quotient bit each), and the output register. Results leave in input
//   order.
//   The receiver cannot stall, so nothing here ever holds.
//   Reset clears all valid bits and the ray registers to zero; triangles
//   in flight are dropped.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  rti_pkg::rti_in_t          triangle,
	output logic                      done,
	output rti_pkg::rti_out_t         result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rti_pkg::IW-1:0]    cfg_index,
	input  logic [rti_pkg::CW-1:0]    cfg_data
);
	import rti_pkg::*;

	rti_v32_t origin_q;
	rti_v32_t dir_q;
	logic     front_valid;
	rti_geo_t geo;
	logic     dot_valid;
	rti_div_t dv;
	logic     div_valid;
	rti_out_t div_res;
	logic     done_q;
	rti_out_t result_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// ray registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			dir_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORIGIN_X:    origin_q.x <= cfg_data;
				REG_ORIGIN_Y:    origin_q.y <= cfg_data;
				REG_ORIGIN_Z:    origin_q.z <= cfg_data;
				REG_DIRECTION_X: dir_q.x    <= cfg_data;
				REG_DIRECTION_Y: dir_q.y    <= cfg_data;
				REG_DIRECTION_Z: dir_q.z    <= cfg_data;
				default: ;
			endcase
		end
	end

	rti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.vtx       (triangle),
		.origin    (origin_q),
		.dir       (dir_q),
		.out_valid (front_valid),
		.geo       (geo)
	);

	rti_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.geo       (geo),
		.out_valid (dot_valid),
		.dv        (dv)
	);

	rti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dot_valid),
		.dv        (dv),
		.out_valid (div_valid),
		.res       (div_res)
	);

	// output register: one-cycle strobe per result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= div_res;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> src/rti_checker.sv
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks on the intersection pipe, bound to the top level.
// ----------------------------------------------------------------------------
module rti_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input rti_pkg::rti_out_t      result,
	input logic                   cfg_ready
);
	import rti_pkg::*;

	// every result beat traces back to a triangle beat at fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 39))
		else $error("result beat without matching triangle beat");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.distance == '0))
		else $error("miss with nonzero distance");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (result.distance != '0))
		else $error("hit with zero distance");

	a_always_open: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("pipe refused a beat");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Ray / triangle intersection testbench
// Drives triangles against a set of ray settings and checks each hit flag and
// distance against an exact wide-integer Moller-Trumbore predictor.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rti_pkg::*;

	localparam int LATENCY = 39;
	localparam int DRAIN   = LATENCY + 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	rti_in_t triangle = '0;
	logic done;
	rti_out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	// ray registers as the block should hold them
	logic signed [CW-1:0] ray_reg [0:7];

	rti_out_t hits_pending [$];
	int errors = 0;
	int n_tri = 0;
	int n_hit = 0;
	bit gaps_on = 1'b1;

	always #2 clk = ~clk;

	ray_triangle_intersect u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.triangle(triangle), .done(done), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// --------------------------------------------------------------------
	// Predictor: exact signed arithmetic at 140 bits, then restoring divide.
	// --------------------------------------------------------------------
	typedef logic signed [139:0] wide_t;

	function automatic wide_t wx(input logic signed [CW-1:0] a);
		wide_t r;
		r = a;
		return r;
	endfunction

	function automatic rti_out_t intersect_ray(input rti_in_t tri_in);
		wide_t ox, oy, oz, dx, dy, dz, ax, ay, az;
		wide_t e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
		wide_t px, py, pz, qx, qy, qz, det, u, v, n, rem;
		logic [QW-1:0] t;
		rti_out_t r;
		ox = wx(ray_reg[REG_ORIGIN_X]);
		oy = wx(ray_reg[REG_ORIGIN_Y]);
		oz = wx(ray_reg[REG_ORIGIN_Z]);
		dx = wx(ray_reg[REG_DIRECTION_X]);
		dy = wx(ray_reg[REG_DIRECTION_Y]);
		dz = wx(ray_reg[REG_DIRECTION_Z]);
		ax = wx(tri_in.vertex_a_x);
		ay = wx(tri_in.vertex_a_y);
		az = wx(tri_in.vertex_a_z);
		e1x = wx(tri_in.vertex_b_x) - ax;
		e1y = wx(tri_in.vertex_b_y) - ay;
		e1z = wx(tri_in.vertex_b_z) - az;
		e2x = wx(tri_in.vertex_c_x) - ax;
		e2y = wx(tri_in.vertex_c_y) - ay;
		e2z = wx(tri_in.vertex_c_z) - az;
		r = '0;
		px = dy * e2z - dz * e2y;
		py = dz * e2x - dx * e2z;
		pz = dx * e2y - dy * e2x;
		det = e1x * px + e1y * py + e1z * pz;
		// back face, parallel, or below one LSB
		if (det < (wide_t'(1) <<< 32))
			return r;
		sx = ox - ax;
		sy = oy - ay;
		sz = oz - az;
		u = sx * px + sy * py + sz * pz;
		if (u < 0 || u > det)
			return r;
		qx = sy * e1z - sz * e1y;
		qy = sz * e1x - sx * e1z;
		qz = sx * e1y - sy * e1x;
		v = dx * qx + dy * qy + dz * qz;
		if (v < 0 || u + v > det)
			return r;
		n = e2x * qx + e2y * qy + e2z * qz;
		if (n <= 0)
			return r;
		if (n >= (det <<< 15)) begin
			t = DIST_MAX;
		end else begin
			t = '0;
			rem = n <<< 16;
			for (int b = QW - 1; b >= 0; b--) begin
				if (rem >= (det <<< b)) begin
					rem = rem - (det <<< b);
					t[b] = 1'b1;
				end
			end
		end
		// t below one LSB: behind or at the origin
		if (t != '0) begin
			r.hit = 1'b1;
			r.distance = t;
		end
		return r;
	endfunction

	// --------------------------------------------------------------------
	// Result checker: every done beat against the oldest prediction.
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		rti_out_t want;
		if (arst_n && done) begin
			if (hits_pending.size() == 0) begin
				$error("result beat with nothing expected: hit=%0b distance=%h",
					result.hit, result.distance);
				errors++;
			end else begin
				want = hits_pending.pop_front();
				if (result.hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, result.hit);
					errors++;
				end
				if (result.distance !== want.distance) begin
					$error("distance: expected %h, got %h", want.distance,
						result.distance);
					errors++;
				end
				if (want.hit)
					n_hit++;
			end
		end
	end

	// --------------------------------------------------------------------
	// Drivers
	// --------------------------------------------------------------------
	task automatic sender_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	// one triangle beat; the prediction is queued at the accepting edge.
	// start stays high afterwards so beats can follow back to back; a gap
	// or a wait for idle drops it.
	task automatic send_triangle(input rti_in_t tri_in);
		sender_gap();
		start <= 1'b1;
		triangle <= tri_in;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		hits_pending.push_back(intersect_ray(tri_in));
		n_tri++;
		@(negedge clk);
	endtask

	// cfg_valid stays high between writes; set_ray drops it at the end
	task automatic write_reg(input rti_reg_e idx, input logic [CW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		ray_reg[idx] = data;
		@(negedge clk);
	endtask

	// wait for the pipe to drain before touching the ray registers
	task automatic wait_idle();
		start <= 1'b0;
		while (hits_pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic set_ray(input logic [CW-1:0] o_x, o_y, o_z, d_x, d_y, d_z);
		wait_idle();
		write_reg(REG_ORIGIN_X, o_x);
		write_reg(REG_ORIGIN_Y, o_y);
		write_reg(REG_ORIGIN_Z, o_z);
		write_reg(REG_DIRECTION_X, d_x);
		write_reg(REG_DIRECTION_Y, d_y);
		write_reg(REG_DIRECTION_Z, d_z);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CW-1:0] fx(input int whole);
		return CW'(whole) << 16;
	endfunction

	function automatic rti_in_t make_tri(input logic [CW-1:0] a_x, a_y, a_z,
			b_x, b_y, b_z, c_x, c_y, c_z);
		rti_in_t t;
		t.vertex_a_x = a_x; t.vertex_a_y = a_y; t.vertex_a_z = a_z;
		t.vertex_b_x = b_x; t.vertex_b_y = b_y; t.vertex_b_z = b_z;
		t.vertex_c_x = c_x; t.vertex_c_y = c_y; t.vertex_c_z = c_z;
		return t;
	endfunction

	// random coordinate: small, mid-range, or any 32-bit pattern
	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return CW'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
			default: return CW'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
		endcase
	endfunction

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------

	// zero ray, then a ray from (0,0,-5) along +z with triangles around the z axis, then a tiny direction and extreme rays
	task automatic test_directed();
		logic [CW-1:0] mx, mn;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		// all-zero ray after reset: det is 0, so a miss
		send_triangle(make_tri(fx(-1), fx(-1), 0, fx(1), fx(-1), 0, 0, fx(1), 0));
		set_ray(0, 0, fx(-5), 0, 0, fx(1));
		// this winding is a back face seen along +z: det is negative, so a miss
		send_triangle(make_tri(fx(-1), fx(-1), 0, fx(1), fx(-1), 0, 0, fx(1), 0));
		// same triangle wound the other way: front face hit, t = 5
		send_triangle(make_tri(fx(-1), fx(-1), 0, 0, fx(1), 0, fx(1), fx(-1), 0));
		// parallel to the ray
		send_triangle(make_tri(0, 0, 0, 0, 0, fx(1), 0, fx(1), 0));
		// meant to fail the first bound, then the second, but wound as back faces: det culls them
		send_triangle(make_tri(fx(2), fx(-1), 0, fx(4), fx(-1), 0, fx(3), fx(1), 0));
		send_triangle(make_tri(fx(-1), fx(2), 0, fx(1), fx(2), 0, 0, fx(4), 0));
		// behind the origin
		send_triangle(make_tri(fx(-1), fx(-1), fx(-9), fx(1), fx(-1), fx(-9),
			0, fx(1), fx(-9)));
		// passes through the origin itself: t is 0
		send_triangle(make_tri(fx(-1), fx(-1), fx(-5), fx(1), fx(-1), fx(-5),
			0, fx(1), fx(-5)));
		// on a vertex and on an edge, but wound as back faces: both miss
		send_triangle(make_tri(0, 0, fx(2), fx(1), 0, fx(2), 0, fx(1), fx(2)));
		send_triangle(make_tri(fx(-1), 0, fx(3), fx(1), 0, fx(3), 0, fx(1), fx(3)));
		// far plane, but wound as a back face: det culls it before any distance
		send_triangle(make_tri(mn, mn, mx, mx, mn, mx, 0, mx, mx));
		// degenerate tiny triangle: det below one LSB
		send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
		// extreme coordinates, all bits toggling
		send_triangle(make_tri(mx, mx, mx, mn, mn, mn, mx, mn, mx));
		send_triangle(make_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx));
		send_triangle(make_tri(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
			1, 0, 1, 32'hFFFF_FFFF));
		// tiny direction, meant for fractional t quotient bits, but both triangles are wound as back faces
		set_ray(fx(0), fx(0), fx(-1), 32'h0000_0001, 32'h0000_0003, 32'h0000_2000);
		send_triangle(make_tri(fx(-1), fx(-1), 0, fx(1), fx(-1), 0, 0, fx(1), 0));
		send_triangle(make_tri(fx(-1), fx(-1), fx(1), fx(1), fx(-1), fx(1),
			0, fx(1), fx(1)));
		// extreme ray registers
		set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_triangle(make_tri(0, 0, 0, 0, fx(1), 0, fx(1), 0, 0));
		send_triangle(make_tri(mx, mn, mn, mn, mx, mn, mn, mn, mx));
		set_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_triangle(make_tri(0, 0, 0, fx(1), 0, 0, 0, fx(1), 0));
		send_triangle(make_tri(mn, mn, mx, mx, mn, mn, mn, mx, mn));
	endtask

	// well-aimed triangles around a random point on the ray, plus noise
	task automatic test_random_batch(input int count);
		logic signed [CW-1:0] ox, oy, oz, dx, dy, dz;
		logic signed [CW-1:0] hx, hy, hz;
		int k, r;
		rti_in_t t;
		ox = CW'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
		oy = CW'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
		oz = CW'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
		dx = CW'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
		dy = CW'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
		dz = CW'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
		if ($urandom_range(0, 7) == 0) begin
			ox = rand_coord(); oy = rand_coord(); oz = rand_coord();
			dx = rand_coord(); dy = rand_coord(); dz = rand_coord();
		end
		set_ray(ox, oy, oz, dx, dy, dz);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				t = make_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
			end else begin
				// point at t = k along the ray, triangle spread r around it
				k = $signed($urandom_range(0, 40)) - 8;
				r = $urandom_range(1, 32'h0004_0000);
				hx = ox + dx * k;
				hy = oy + dy * k;
				hz = oz + dz * k;
				t = make_tri(
					hx + CW'($signed($urandom_range(0, 2 * r)) - r),
					hy + CW'($signed($urandom_range(0, 2 * r)) - r),
					hz + CW'($signed($urandom_range(0, 2 * r)) - r),
					hx + CW'($signed($urandom_range(0, 2 * r)) - r),
					hy + CW'($signed($urandom_range(0, 2 * r)) - r),
					hz + CW'($signed($urandom_range(0, 2 * r)) - r),
					hx + CW'($signed($urandom_range(0, 2 * r)) - r),
					hy + CW'($signed($urandom_range(0, 2 * r)) - r),
					hz + CW'($signed($urandom_range(0, 2 * r)) - r));
			end
			send_triangle(t);
		end
	endtask

	// pause until the pipe is empty, then stream back to back
	task automatic test_drain_and_burst();
		wait_idle();
		gaps_on = 1'b0;
		test_random_batch(60);
	endtask

	initial begin
		for (int i = 0; i < 8; i++)
			ray_reg[i] = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		for (int b = 0; b < 11; b++)
			test_random_batch(40);
		test_drain_and_burst();
		wait_idle();
		$display("Covered %0d triangles over %0d ray settings, %0d hits seen.",
			n_tri, 17, n_hit);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

endmodule
